// ===== rtl/assert_macros.svh =====
// assertion helpers used by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rstn, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rstn, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== rtl/sem_pkg.sv =====
package sem_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int CFG_W          = 11;
  localparam int PIX_W          = 24;
  localparam int POS_W          = 10;

  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  localparam int ROOT_CLAMP_LIMIT = 65280;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_GRAD,
    ST_SQUARE,
    ST_ROOT,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic       accept;
    logic       shift;
    logic       grad;
    logic       square;
    logic       root;
    logic       load;
    logic [1:0] sel;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [3:0] avail;
    logic       root_done;
    logic       out_free;
  } status_t;

endpackage

// ===== rtl/sem_ram.sv =====
module sem_ram import sem_pkg::*; #(
  parameter int WIDTH = 2 * PIX_W,
  parameter int DEPTH = DEF_MAX_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sem_ctrl.sv =====
module sem_ctrl import sem_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e     state_q, state_d;
  logic [1:0] idx_q, idx_d;
  logic       any_above;
  logic [1:0] next_idx;
  logic       any_first;
  logic [1:0] first_idx;

  always_comb begin
    any_above = 1'b0;
    next_idx  = idx_q;
    for (int k = 3; k >= 0; k--) begin
      if (status_i.avail[k] && (2'(k) > idx_q)) begin
        any_above = 1'b1;
        next_idx  = 2'(k);
      end
    end
    any_first = 1'b0;
    first_idx = 2'd0;
    for (int k = 3; k >= 0; k--) begin
      if (status_i.avail[k]) begin
        any_first = 1'b1;
        first_idx = 2'(k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cmd_o      = '0;
    cmd_o.sel  = idx_q;
    cmd_o.last = !any_above;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (any_first) begin
          idx_d   = first_idx;
          state_d = ST_GRAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_GRAD: begin
        cmd_o.grad = 1'b1;
        state_d    = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root = 1'b1;
        if (status_i.root_done) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          if (any_above) begin
            idx_d   = next_idx;
            state_d = ST_GRAD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/sem_datapath.sv =====
module sem_datapath import sem_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic [PIX_W-1:0] in_pix_i,
  input  logic             in_start_i,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_red_o,
  output logic [7:0]       out_green_o,
  output logic [7:0]       out_blue_o,
  output logic [POS_W-1:0] out_row_o,
  output logic [POS_W-1:0] out_col_o,
  output logic             out_last_o,
  output logic             out_done_o
);

  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 1);
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int CWC = (CW > CFG_W) ? CW : CFG_W;
  localparam int RWC = (RW > CFG_W) ? RW : CFG_W;
  localparam int RST_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int RST_H = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

  logic [CFG_W-1:0] width_q, height_q;
  logic [CW-1:0]    w_eff;
  logic [RW-1:0]    h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(RST_W);
      height_q <= CFG_W'(RST_H);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (CWC'(width_q) == '0) begin
      w_eff = CW'(1);
    end else if (CWC'(width_q) > CWC'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(width_q);
    end
    if (RWC'(height_q) == '0) begin
      h_eff = RW'(1);
    end else if (RWC'(height_q) > RWC'(MAX_HEIGHT)) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(height_q);
    end
  end

  // position counters
  logic [CW-1:0]    col_q, cur_c_q;
  logic [RW-1:0]    row_q, cur_r_q;
  logic [3:0]       avail_q;
  logic [PIX_W-1:0] px_q;
  logic [CW-1:0]    c0, col_n;
  logic [RW-1:0]    r0, row_n;

  always_comb begin
    c0 = in_start_i ? '0 : col_q;
    r0 = in_start_i ? '0 : row_q;
    if (c0 >= w_eff) begin
      c0 = '0;
      r0 = RW'(r0 + RW'(1));
    end
    if (r0 >= h_eff) begin
      r0 = '0;
    end
    col_n = CW'(c0 + CW'(1));
    row_n = r0;
    if (col_n >= w_eff) begin
      col_n = '0;
      row_n = (RW'(r0 + RW'(1)) >= h_eff) ? '0 : RW'(r0 + RW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      avail_q <= '0;
    end else if (cmd_i.accept) begin
      col_q      <= col_n;
      row_q      <= row_n;
      avail_q[0] <= (r0 != '0) && (c0 != '0);
      avail_q[1] <= (r0 != '0) && (c0 == CW'(w_eff - CW'(1)));
      avail_q[2] <= (r0 == RW'(h_eff - RW'(1))) && (c0 != '0);
      avail_q[3] <= (r0 == RW'(h_eff - RW'(1))) && (c0 == CW'(w_eff - CW'(1)));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_c_q <= c0;
      cur_r_q <= r0;
      px_q    <= in_pix_i;
    end
  end

  // line store: upper half two rows above, lower half one row above
  logic [2*PIX_W-1:0] line_rd;

  sem_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.shift),
    .waddr_i (cur_c_q[AW-1:0]),
    .wdata_i ({line_rd[PIX_W-1:0], px_q}),
    .re_i    (cmd_i.accept),
    .raddr_i (c0[AW-1:0]),
    .rdata_o (line_rd)
  );

  // 3x3 window
  logic [PIX_W-1:0] win_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (cmd_i.shift) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= line_rd[2*PIX_W-1:PIX_W];
      win_q[1][2] <= line_rd[PIX_W-1:0];
      win_q[2][2] <= px_q;
    end
  end

  // neighborhood select with zero outside the image
  logic [PIX_W-1:0] nb [3][3];

  always_comb begin
    logic [2:0] wr, wc;
    logic       ok;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        wr = 3'(i) + {2'b00, cmd_i.sel[1]};
        wc = 3'(j) + {2'b00, cmd_i.sel[0]};
        ok = (wr < 3'd3) && (wc < 3'd3) &&
             ((RW + 3)'(cur_r_q) + (RW + 3)'(wr) >= (RW + 3)'(2)) &&
             ((CW + 3)'(cur_c_q) + (CW + 3)'(wc) >= (CW + 3)'(2));
        nb[i][j] = ok ? win_q[wr[1:0]][wc[1:0]] : '0;
      end
    end
  end

  function automatic logic signed [11:0] px8(input logic [7:0] v);
    return $signed({4'b0000, v});
  endfunction

  logic signed [11:0] gx_q [3], gy_q [3];
  logic [20:0]        s_q [3];
  logic [7:0]         root_q [3];
  logic [2:0]         bit_q;

  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (cmd_i.grad) begin
        gx_q[ch] <= px8(nb[0][2][8*ch +: 8]) - px8(nb[0][0][8*ch +: 8])
                  + 12'sd2 * (px8(nb[1][2][8*ch +: 8]) - px8(nb[1][0][8*ch +: 8]))
                  + px8(nb[2][2][8*ch +: 8]) - px8(nb[2][0][8*ch +: 8]);
        gy_q[ch] <= px8(nb[2][0][8*ch +: 8]) - px8(nb[0][0][8*ch +: 8])
                  + 12'sd2 * (px8(nb[2][1][8*ch +: 8]) - px8(nb[0][1][8*ch +: 8]))
                  + px8(nb[2][2][8*ch +: 8]) - px8(nb[0][2][8*ch +: 8]);
      end
      if (cmd_i.square) begin
        s_q[ch]    <= 21'($unsigned(24'(gx_q[ch]) * 24'(gx_q[ch])))
                    + 21'($unsigned(24'(gy_q[ch]) * 24'(gy_q[ch])));
        root_q[ch] <= '0;
      end
      if (cmd_i.root) begin
        if (21'(16'(root_q[ch] | (8'd1 << bit_q)) * 16'(root_q[ch] | (8'd1 << bit_q)))
            <= s_q[ch]) begin
          root_q[ch] <= root_q[ch] | (8'd1 << bit_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 3'd7;
    end else if (cmd_i.square) begin
      bit_q <= 3'd7;
    end else if (cmd_i.root) begin
      bit_q <= bit_q - 3'd1;
    end
  end

  // round to nearest and clamp
  logic [7:0] mag [3];

  always_comb begin
    logic [15:0] sq;
    for (int ch = 0; ch < 3; ch++) begin
      sq = 16'(root_q[ch]) * 16'(root_q[ch]);
      if (s_q[ch] > 21'(ROOT_CLAMP_LIMIT)) begin
        mag[ch] = 8'hff;
      end else if (21'(s_q[ch] - 21'(sq)) > 21'(root_q[ch])) begin
        mag[ch] = root_q[ch] + 8'd1;
      end else begin
        mag[ch] = root_q[ch];
      end
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_red_o   <= mag[2];
      out_green_o <= mag[1];
      out_blue_o  <= mag[0];
      out_row_o   <= POS_W'(POS_W'(cur_r_q) - POS_W'(1) + POS_W'(cmd_i.sel[1]));
      out_col_o   <= POS_W'(POS_W'(cur_c_q) - POS_W'(1) + POS_W'(cmd_i.sel[0]));
      out_last_o  <= cmd_i.last;
      out_done_o  <= (cmd_i.sel == 2'd3);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.avail     = avail_q;
  assign status_o.root_done = (bit_q == 3'd0);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ===== rtl/sobel_edge_magnitude_rgb_core.sv =====
// channel  direction  tdata (low bit up)                         tuser        tlast
// s_axis   in         in_red, in_green, in_blue                  frame_start  -
// m_axis   out        out_red, out_green, out_blue, row, col     frame_done   out_last
// cfg      in         write port, index 0 width, 1 height        -            -
// a pixel that releases nothing passes the idle and shift states; each result it releases (up to 4)
// then passes grad, square, the 8-step bit-serial square root shared by the results, and load
// reset is asynchronous and active low; line buffers need no clearing pass
// a stalled result stalls the pixel that follows only once the next result is ready
module sobel_edge_magnitude_rgb_core import sem_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [23:0]      s_axis_tdata,  // in_red, in_green, in_blue
  input  logic             s_axis_tuser,  // frame_start
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // out_red, out_green, out_blue, out_row, out_col
  output logic             m_axis_tuser,  // frame_done
  output logic             m_axis_tlast
);

  `include "assert_macros.svh"

  cmd_t             cmd;
  status_t          status;
  logic [7:0]       red, green, blue;
  logic [POS_W-1:0] row, col;

  sem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sem_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_pix_i    ({s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]}),
    .in_start_i  (s_axis_tuser),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_red_o   (red),
    .out_green_o (green),
    .out_blue_o  (blue),
    .out_row_o   (row),
    .out_col_o   (col),
    .out_last_o  (m_axis_tlast),
    .out_done_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {4'b0000, col, row, blue, green, red};

  `ASSERT_NXT(a_no_back_to_back, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `ASSERT_IMP(a_done_is_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
  `ASSERT_NXT(a_load_sets_valid, clk_i, rst_ni, cmd.load, m_axis_tvalid)

endmodule
